/* hw/rtl/amcc_pkg.sv */
package amcc_pkg;

  localparam int SAMPLE_W   = 10;
  localparam int SW_W       = 3;
  localparam int DUTY_W     = 8;
  localparam int RUN_W      = 11;
  localparam int DEB_W      = 8;
  localparam int NUM_COMBOS = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 10;

  // Switch combinations that the transition table knows.
  localparam logic [SW_W-1:0] SW_AUTO_UP     = 3'b110;
  localparam logic [SW_W-1:0] SW_AUTO_DOWN   = 3'b000;
  localparam logic [SW_W-1:0] SW_MANUAL_UP   = 3'b111;
  localparam logic [SW_W-1:0] SW_MANUAL_DOWN = 3'b010;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CURRENT_LIMIT,
    REG_STALL_LEVEL,
    REG_STALL_COUNT_LIMIT,
    REG_DEBOUNCE_LIMIT
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ACT_NONE,
    ACT_STOP,
    ACT_DOWN,
    ACT_UP
  } act_t;

  // Live register values, to be written only while the block is idle; the block itself does not enforce this.
  typedef struct packed {
    logic [SAMPLE_W-1:0] current_limit;
    logic [SAMPLE_W-1:0] stall_level;
    logic [SAMPLE_W-1:0] stall_count_limit;
    logic [DEB_W-1:0]    debounce_limit;
  } amcc_cfg_t;

  // One classified sample tick as it sits in the queue.
  typedef struct packed {
    logic            above_stall;
    logic            below_limit;
    logic [SW_W-1:0] switch_bits;
  } amcc_item_t;

endpackage

/* hw/rtl/amcc_front.sv */
module amcc_front
  import amcc_pkg::*;
(
  input  amcc_cfg_t           cfg,
  input  logic [SAMPLE_W-1:0] current_sample,
  input  logic [SW_W-1:0]     switch_bits,
  output amcc_item_t          item
);

  // The sample is reduced to the two comparisons the back end needs.
  always_comb begin
    item.above_stall = current_sample > cfg.stall_level;
    item.below_limit = current_sample < cfg.current_limit;
    item.switch_bits = switch_bits;
  end

endmodule

/* hw/rtl/amcc_queue.sv */
module amcc_queue
  import amcc_pkg::*;
#(
  parameter int DEPTH = 2
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  amcc_item_t push_item,
  output logic       full,
  input  logic       pop,
  output logic       not_empty,
  output amcc_item_t head
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  amcc_item_t        mem_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;

  assign full      = (cnt_r == CNT_W'(DEPTH));
  assign not_empty = (cnt_r != '0);
  assign head      = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

`ifndef SYNTHESIS
  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full)
    else $error("queue written while full");

  a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> not_empty)
    else $error("queue read while empty");

  a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(DEPTH))
    else $error("queue count beyond its depth");
`endif

endmodule

/* hw/rtl/amcc_back.sv */
module amcc_back
  import amcc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  amcc_cfg_t         cfg,
  input  logic              q_not_empty,
  input  amcc_item_t        q_head,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [DUTY_W-1:0] out_pwm_duty,
  output logic              out_motor_enabled,
  output logic              out_direction_up,
  output logic [SW_W-1:0]   out_settled_switches,
  output logic              out_stall_stopped
);

  localparam logic [RUN_W-1:0]  RUN_MAX  = '1;
  localparam logic [DUTY_W-1:0] DUTY_MAX = '1;

  function automatic act_t pick_action(input logic [SW_W-1:0] from_sw,
                                       input logic [SW_W-1:0] to_sw);
    act_t act;
    act = ACT_NONE;
    priority if ((from_sw == SW_MANUAL_DOWN || from_sw == SW_MANUAL_UP) &&
                 (to_sw == SW_AUTO_UP || to_sw == SW_AUTO_DOWN)) begin
      act = ACT_STOP;
    end else if (from_sw == SW_AUTO_UP &&
                 (to_sw == SW_AUTO_DOWN || to_sw == SW_MANUAL_DOWN)) begin
      act = ACT_DOWN;
    end else if ((from_sw == SW_AUTO_DOWN || from_sw == SW_MANUAL_UP) &&
                 to_sw == SW_MANUAL_DOWN) begin
      act = ACT_DOWN;
    end else if (from_sw == SW_AUTO_UP && to_sw == SW_MANUAL_UP) begin
      act = ACT_UP;
    end else if (from_sw == SW_AUTO_DOWN &&
                 (to_sw == SW_AUTO_UP || to_sw == SW_MANUAL_UP)) begin
      act = ACT_UP;
    end else if (from_sw == SW_MANUAL_DOWN && to_sw == SW_MANUAL_UP) begin
      act = ACT_UP;
    end else begin
      act = ACT_NONE;
    end
    return act;
  endfunction

  // Controller state.
  logic [DUTY_W-1:0] duty_r, duty_nxt;
  logic              enable_r, enable_nxt;
  logic              dir_r, dir_nxt;
  logic [RUN_W-1:0]  run_r, run_nxt;
  logic [DEB_W-1:0]  cnt_r [NUM_COMBOS];
  logic [DEB_W-1:0]  cnt_nxt [NUM_COMBOS];
  logic [SW_W-1:0]   settled_now_r, settled_now_nxt;
  logic [SW_W-1:0]   settled_before_r, settled_before_nxt;

  // Result register.
  logic              out_valid_r, out_valid_nxt;
  logic [DUTY_W-1:0] out_duty_r;
  logic              out_en_r;
  logic              out_dir_r;
  logic [SW_W-1:0]   out_settled_r;
  logic              out_stall_r;

  logic [RUN_W-1:0]  run_inc;
  logic              stalled;
  logic              en_reg;
  logic [DUTY_W-1:0] duty_reg;
  logic [DEB_W-1:0]  sel_cnt;
  logic              changed;
  act_t              act;
  logic [SW_W-1:0]   sw;

  assign q_pop = q_not_empty && (!out_valid_r || out_ready);
  assign sw    = q_head.switch_bits;

  always_comb begin
    // Stall guard.
    if (q_head.above_stall) begin
      run_inc = (run_r == RUN_MAX) ? run_r : run_r + RUN_W'(1);
    end else begin
      run_inc = '0;
    end
    stalled = run_inc > RUN_W'(cfg.stall_count_limit);
    run_nxt = stalled ? '0 : run_inc;
    en_reg  = stalled ? 1'b0 : enable_r;

    // Current regulation.
    if (!en_reg) begin
      duty_reg = '0;
    end else if (q_head.below_limit) begin
      duty_reg = (duty_r == DUTY_MAX) ? duty_r : duty_r + DUTY_W'(1);
    end else begin
      duty_reg = (duty_r == '0) ? duty_r : duty_r - DUTY_W'(1);
    end

    // Debounce: only the present combination keeps counting.
    sel_cnt = '0;
    for (int k = 0; k < NUM_COMBOS; k++) begin
      if (SW_W'(k) == sw) begin
        sel_cnt    = cnt_r[k];
        cnt_nxt[k] = (cnt_r[k] < cfg.debounce_limit) ? cnt_r[k] + DEB_W'(1) : cnt_r[k];
      end else begin
        cnt_nxt[k] = '0;
      end
    end
    changed            = (sel_cnt >= cfg.debounce_limit) && (settled_now_r != sw);
    settled_now_nxt    = changed ? sw : settled_now_r;
    settled_before_nxt = changed ? settled_now_r : settled_before_r;

    // Transition table on the (previous, new) settled pair.
    act        = changed ? pick_action(settled_now_r, sw) : ACT_NONE;
    duty_nxt   = duty_reg;
    enable_nxt = en_reg;
    dir_nxt    = dir_r;
    unique case (act)
      ACT_STOP: begin
        enable_nxt = 1'b0;
      end
      ACT_DOWN, ACT_UP: begin
        dir_nxt    = (act == ACT_UP);
        duty_nxt   = DUTY_MAX;
        enable_nxt = 1'b1;
      end
      default: begin
      end
    endcase

    if (q_pop) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      duty_r           <= '0;
      enable_r         <= 1'b0;
      dir_r            <= 1'b0;
      run_r            <= '0;
      settled_now_r    <= '0;
      settled_before_r <= '0;
      out_valid_r      <= 1'b0;
      for (int k = 0; k < NUM_COMBOS; k++) begin
        cnt_r[k] <= '0;
      end
    end else begin
      out_valid_r <= out_valid_nxt;
      if (q_pop) begin
        duty_r           <= duty_nxt;
        enable_r         <= enable_nxt;
        dir_r            <= dir_nxt;
        run_r            <= run_nxt;
        settled_now_r    <= settled_now_nxt;
        settled_before_r <= settled_before_nxt;
        for (int k = 0; k < NUM_COMBOS; k++) begin
          cnt_r[k] <= cnt_nxt[k];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      out_duty_r    <= duty_nxt;
      out_en_r      <= enable_nxt;
      out_dir_r     <= dir_nxt;
      out_settled_r <= settled_now_nxt;
      out_stall_r   <= stalled;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_pwm_duty         = out_duty_r;
  assign out_motor_enabled    = out_en_r;
  assign out_direction_up     = out_dir_r;
  assign out_settled_switches = out_settled_r;
  assign out_stall_stopped    = out_stall_r;

`ifndef SYNTHESIS
  a_pop_loads_result: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> out_valid_r)
    else $error("popped item produced no result");

  a_stall_clears_run: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall_r) |-> (run_r == '0))
    else $error("stall reported but run counter not cleared");

  a_settle_history: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(q_pop) && settled_now_r != $past(settled_now_r)) |->
      (settled_before_r == $past(settled_now_r)))
    else $error("previous settled combination not kept");
`endif

endmodule

/* hw/rtl/antenna_motor_current_controller.sv */
// A sample taken in is first written into the queue; once the back end pops it, its
// result is loaded into the output register and then shows on out_valid.
// Throughput: one sample per cycle; the back end retires one queued sample each
// cycle that its output register is free or being drained.
// Reset (rst_n low, synchronous) clears the duty, enable, direction, stall run,
// debounce counters, settled state and queue, and restores register defaults.
module antenna_motor_current_controller
  import amcc_pkg::*;
#(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [SAMPLE_W-1:0]   in_current_sample,
  input  logic [SW_W-1:0]       in_switch_bits,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [DUTY_W-1:0]     out_pwm_duty,
  output logic                  out_motor_enabled,
  output logic                  out_direction_up,
  output logic [SW_W-1:0]       out_settled_switches,
  output logic                  out_stall_stopped,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  amcc_cfg_t  cfg_r;
  amcc_item_t front_item;
  amcc_item_t q_head;
  logic       q_full;
  logic       q_not_empty;
  logic       q_pop;
  logic       push;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.current_limit     <= SAMPLE_W'(800);
      cfg_r.stall_level       <= SAMPLE_W'(700);
      cfg_r.stall_count_limit <= SAMPLE_W'(255);
      cfg_r.debounce_limit    <= DEB_W'(255);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_CURRENT_LIMIT:     cfg_r.current_limit     <= cfg_wdata;
        REG_STALL_LEVEL:       cfg_r.stall_level       <= cfg_wdata;
        REG_STALL_COUNT_LIMIT: cfg_r.stall_count_limit <= cfg_wdata;
        REG_DEBOUNCE_LIMIT:    cfg_r.debounce_limit    <= cfg_wdata[DEB_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign in_ready = !q_full;
  assign push     = in_valid && in_ready;

  amcc_front u_front (
    .cfg            (cfg_r),
    .current_sample (in_current_sample),
    .switch_bits    (in_switch_bits),
    .item           (front_item)
  );

  amcc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (front_item),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head      (q_head)
  );

  amcc_back u_back (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg                  (cfg_r),
    .q_not_empty          (q_not_empty),
    .q_head               (q_head),
    .q_pop                (q_pop),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_pwm_duty         (out_pwm_duty),
    .out_motor_enabled    (out_motor_enabled),
    .out_direction_up     (out_direction_up),
    .out_settled_switches (out_settled_switches),
    .out_stall_stopped    (out_stall_stopped)
  );

endmodule
